[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Every check is clocked on i_clk;
// ASSERT_CLK is switched off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, disabled in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/irpd_pkg.sv]
package irpd_pkg;

    localparam int FRAME_BITS = 28;
    localparam int CNT_W      = $clog2(FRAME_BITS + 1);
    localparam int LEN_W      = 15;
    localparam int CODE_W     = 28;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;

    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [FRAME_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [CODE_W-1:0]     t_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_BIT    = 2'd2,
        ST_TRUNC      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_BITS  = 4'b0010,
        PH_TRAIL = 4'b0100,
        PH_DROP  = 4'b1000
    } t_phase;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MARK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY     = 3'd7;

    localparam t_len RST_HEADER_MARK  = 15'd8400;
    localparam t_len RST_HEADER_SPACE = 15'd4200;
    localparam t_len RST_ONE_MARK     = 15'd550;
    localparam t_len RST_ONE_SPACE    = 15'd1600;
    localparam t_len RST_ZERO_MARK    = 15'd550;
    localparam t_len RST_ZERO_SPACE   = 15'd550;
    localparam t_len RST_TOLERANCE    = 15'd200;

endpackage

[hw/rtl/ir_pulse_distance_frame_decoder.sv]
// Channel   Direction  tdata (low bit up)                         tuser / tlast
// s_axis    in         first_level, first_length, second_level,   tlast = burst_end
//                      second_length (32 bits)
// m_axis    out        frame_code, zero pad to 32 bits            tuser = status
// cfg       in         i_cfg_idx selects register, i_cfg_data     write on i_cfg_we
//
// One pulse pair is accepted per cycle unless a stalled result blocks the input register;
// its result, if any, is presented from the result register: the input register takes
// the pair at the accepting edge and the result register takes the outcome as the pair advances.
// Reset is synchronous and active low; it restores the register defaults and
// sends the decoder back to waiting for a header.
// A stalled result holds the result register; the input register still takes
// one more transaction, after which s_axis_tready drops until the result leaves.
`include "assert_macros.svh"

module ir_pulse_distance_frame_decoder
    import irpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_level[0], first_length[15:1], second_level[16], second_length[31:17]
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // frame_code[27:0], zero[31:28]
    output logic [31:0]          m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_len   r_hdr_mark, r_hdr_space, r_one_mark, r_one_space;
    t_len   r_zero_mark, r_zero_space, r_tol;
    logic   r_pol;

    logic   r_in_valid;
    logic   r_first_level, r_second_level, r_last;
    t_len   r_first_len, r_second_len;

    t_phase  r_phase, n_phase;
    t_count  r_bits, n_bits;
    t_word   r_shift, n_shift;

    logic    r_out_valid;
    t_code   r_out_code;
    t_status r_out_status;

    logic    advance;
    logic    emit;
    t_code   emit_code;
    t_status emit_status;
    logic    hdr_ok, one_ok, zero_ok;

    function automatic logic near_target(t_len d, t_len t, t_len m);
        logic [LEN_W:0] dd, tt, mm;
        dd = {1'b0, d};
        tt = {1'b0, t};
        mm = {1'b0, m};
        return (dd < tt + mm) && (dd + mm > tt);
    endfunction

    // A pair is usable only as active level followed by inactive level.
    function automatic logic pair_fits(logic l0, t_len d0, logic l1, t_len d1,
                                       logic pol, t_len mark, t_len space, t_len m);
        return (l0 == pol) && (l1 != pol) &&
               near_target(d0, mark, m) && near_target(d1, space, m);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mark   <= RST_HEADER_MARK;
            r_hdr_space  <= RST_HEADER_SPACE;
            r_one_mark   <= RST_ONE_MARK;
            r_one_space  <= RST_ONE_SPACE;
            r_zero_mark  <= RST_ZERO_MARK;
            r_zero_space <= RST_ZERO_SPACE;
            r_tol        <= RST_TOLERANCE;
            r_pol        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_MARK:  r_hdr_mark   <= i_cfg_data;
                CFG_HEADER_SPACE: r_hdr_space  <= i_cfg_data;
                CFG_ONE_MARK:     r_one_mark   <= i_cfg_data;
                CFG_ONE_SPACE:    r_one_space  <= i_cfg_data;
                CFG_ZERO_MARK:    r_zero_mark  <= i_cfg_data;
                CFG_ZERO_SPACE:   r_zero_space <= i_cfg_data;
                CFG_TOLERANCE:    r_tol        <= i_cfg_data;
                CFG_POLARITY:     r_pol        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The held pair moves on once the result register is free or emptying.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_first_level  <= s_axis_tdata[0];
            r_first_len    <= s_axis_tdata[15:1];
            r_second_level <= s_axis_tdata[16];
            r_second_len   <= s_axis_tdata[31:17];
            r_last         <= s_axis_tlast;
        end
    end

    assign hdr_ok  = pair_fits(r_first_level, r_first_len, r_second_level, r_second_len,
                               r_pol, r_hdr_mark, r_hdr_space, r_tol);
    assign one_ok  = pair_fits(r_first_level, r_first_len, r_second_level, r_second_len,
                               r_pol, r_one_mark, r_one_space, r_tol);
    assign zero_ok = pair_fits(r_first_level, r_first_len, r_second_level, r_second_len,
                               r_pol, r_zero_mark, r_zero_space, r_tol);

    always_comb begin
        n_phase     = r_phase;
        n_bits      = r_bits;
        n_shift     = r_shift;
        emit        = 1'b0;
        emit_code   = '0;
        emit_status = ST_OK;
        unique case (r_phase)
            PH_WAIT: begin
                if (!hdr_ok) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_HEADER;
                    n_phase     = r_last ? PH_WAIT : PH_DROP;
                end else begin
                    n_bits  = '0;
                    n_shift = '0;
                    if (r_last) begin
                        emit        = 1'b1;
                        emit_status = ST_TRUNC;
                        n_phase     = PH_WAIT;
                    end else begin
                        n_phase = PH_BITS;
                    end
                end
            end
            PH_BITS: begin
                if (!one_ok && !zero_ok) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_BIT;
                    n_bits      = '0;
                    n_phase     = r_last ? PH_WAIT : PH_DROP;
                end else begin
                    // A pair that fits both bit shapes counts as a one.
                    n_shift = (r_shift << 1) | FRAME_BITS'(one_ok);
                    if (r_bits == CNT_W'(FRAME_BITS - 1)) begin
                        emit      = 1'b1;
                        emit_code = CODE_W'(n_shift);
                        n_bits    = '0;
                        n_phase   = r_last ? PH_WAIT : PH_TRAIL;
                    end else if (r_last) begin
                        emit        = 1'b1;
                        emit_status = ST_TRUNC;
                        n_bits      = '0;
                        n_phase     = PH_WAIT;
                    end else begin
                        n_bits = r_bits + 1'b1;
                    end
                end
            end
            PH_TRAIL: begin
                n_phase = PH_WAIT;
            end
            PH_DROP: begin
                if (r_last) begin
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                n_bits  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_bits  <= '0;
            r_shift <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_code   <= emit_code;
            r_out_status <= emit_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(32 - CODE_W){1'b0}}, r_out_code};
    assign m_axis_tuser  = r_out_status;

    `ASSERT_CLK(a_err_code_zero, (r_out_valid && r_out_status != ST_OK) |-> (r_out_code == '0), "error result carries a non-zero frame code")
    `ASSERT_CLK(a_count_idle, (r_phase != PH_BITS) |-> (r_bits == '0), "bit count left non-zero outside the bit phase")
    `ASSERT_CLK(a_full_stall, (r_in_valid && r_out_valid && !m_axis_tready) |-> (!s_axis_tready ##1 $stable(r_phase)), "input taken while both stages are blocked")

endmodule
